>>> hdl/sbc_pkg.sv
// Package for the selectable byte checksum core.
// Holds mode codes, register indexes and the per-byte CRC and modulo helpers.
// No dependencies.
package sbc_pkg;

   typedef logic [2:0]  mode_type;
   typedef logic [1:0]  csr_index_type;
   typedef logic [15:0] crc_type;

   localparam mode_type MODE_CRC     = 3'd0;
   localparam mode_type MODE_ADLER   = 3'd1;
   localparam mode_type MODE_F255    = 3'd2;
   localparam mode_type MODE_F256    = 3'd3;
   localparam mode_type MODE_DOUBLED = 3'd4;

   localparam csr_index_type CSR_MODE        = 2'd0;
   localparam csr_index_type CSR_POLYNOMIAL  = 2'd1;
   localparam csr_index_type CSR_INITIAL     = 2'd2;

   localparam crc_type  POLY_RESET    = 16'h1021;
   localparam crc_type  INITIAL_RESET = 16'hFFFF;
   localparam logic [7:0] MOD_ADLER   = 8'd251;
   localparam logic [7:0] MOD_F255    = 8'd255;

   // MSB-first CRC over one byte, eight shift steps unrolled.
   function automatic crc_type crc_byte(input crc_type crc, input logic [7:0] data,
                                        input crc_type poly);
      crc_type c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ poly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   // Reduce a value below three times the modulus: two compare-subtract steps.
   function automatic logic [7:0] mod_reduce(input logic [8:0] value,
                                             input logic [7:0] modulus);
      logic [8:0] v;
      v = value;
      if (v >= {1'b0, modulus}) begin
         v = v - {1'b0, modulus};
      end
      if (v >= {1'b0, modulus}) begin
         v = v - {1'b0, modulus};
      end
      return v[7:0];
   endfunction

endpackage

>>> hdl/selectable_byte_checksum_core.sv
// Selectable byte checksum core: top level.
// CRC-16, Adler-16 and Fletcher-16 variants over a byte stream.
// Depends on sbc_pkg.
//
// Usage:
//   Bytes enter on the req_ channel (req_valid / req_stall) with first and
//   last flags. A byte marked first loads the start values of the selected
//   algorithm before it is taken in; a byte marked last produces one
//   checksum beat on the rsp_ channel (rsp_valid / rsp_stall).
//   Configuration goes through csr_write_enable / csr_index / csr_write_data:
//   index 0 mode, 1 CRC polynomial, 2 CRC initial value. Write only while idle.
//   Throughput: one byte per cycle while no result beat waits on a stalled rsp_;
//   all update logic of a byte (eight unrolled CRC steps or two adds with two
//   compare-subtracts each) sits in front of the sum registers, so the next byte is taken in the next cycle.
//   Result: the checksum is registered in the rsp_ output register in the cycle
//   after the last byte is accepted.
//   When the receiver stalls, the checksum holds in the output register and
//   req_stall rises only while that beat waits; a new byte is still taken in
//   the same cycle that the waiting beat leaves.
//   Reset (synchronous): mode CRC, polynomial 0x1021, initial 0xFFFF, sums
//   cleared, no result pending.
module selectable_byte_checksum_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_first_of_block,
   input  logic                   req_last_of_block,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [15:0]            rsp_checksum,
   input  logic                   csr_write_enable,
   input  sbc_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_write_data
);

   sbc_pkg::mode_type mode_ff;
   sbc_pkg::crc_type  poly_ff;
   sbc_pkg::crc_type  initial_ff;
   logic [15:0]       first_sum_ff, first_sum_in;
   logic [7:0]        second_sum_ff, second_sum_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_checksum_ff, rsp_checksum_in;

   logic              accept;
   sbc_pkg::mode_type mode_eff;
   sbc_pkg::crc_type  crc_start;
   sbc_pkg::crc_type  crc_next;
   logic [7:0]        a_start, b_start, a_next, b_next;
   logic [8:0]        a_sum, b_sum;

   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign accept       = req_valid & ~req_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_checksum = rsp_checksum_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= sbc_pkg::MODE_CRC;
         poly_ff    <= sbc_pkg::POLY_RESET;
         initial_ff <= sbc_pkg::INITIAL_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            sbc_pkg::CSR_MODE:       mode_ff    <= csr_write_data[2:0];
            sbc_pkg::CSR_POLYNOMIAL: poly_ff    <= csr_write_data;
            sbc_pkg::CSR_INITIAL:    initial_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      // Unused mode codes behave as plain mod-256 Fletcher.
      mode_eff = (mode_ff > sbc_pkg::MODE_DOUBLED) ? sbc_pkg::MODE_F256 : mode_ff;

      crc_start = req_first_of_block ? initial_ff : first_sum_ff;
      crc_next  = sbc_pkg::crc_byte(crc_start, req_data_byte, poly_ff);

      a_start = first_sum_ff[7:0];
      b_start = second_sum_ff;
      if (req_first_of_block) begin
         b_start = 8'd0;
         case (mode_eff)
            sbc_pkg::MODE_ADLER:   a_start = 8'd1;
            sbc_pkg::MODE_DOUBLED: a_start = req_data_byte;
            default:               a_start = 8'd0;
         endcase
      end

      a_sum = {1'b0, a_start} + {1'b0, req_data_byte};
      case (mode_eff)
         sbc_pkg::MODE_ADLER: a_next = sbc_pkg::mod_reduce(a_sum, sbc_pkg::MOD_ADLER);
         sbc_pkg::MODE_F255:  a_next = sbc_pkg::mod_reduce(a_sum, sbc_pkg::MOD_F255);
         default:             a_next = a_sum[7:0];
      endcase

      b_sum = {1'b0, b_start} + {1'b0, a_next};
      case (mode_eff)
         sbc_pkg::MODE_ADLER: b_next = sbc_pkg::mod_reduce(b_sum, sbc_pkg::MOD_ADLER);
         sbc_pkg::MODE_F255:  b_next = sbc_pkg::mod_reduce(b_sum, sbc_pkg::MOD_F255);
         default:             b_next = b_sum[7:0];
      endcase

      first_sum_in    = first_sum_ff;
      second_sum_in   = second_sum_ff;
      rsp_checksum_in = rsp_checksum_ff;
      // Hold a stalled beat, drop a taken one.
      rsp_valid_in    = rsp_valid_ff & rsp_stall;
      if (accept) begin
         if (mode_eff == sbc_pkg::MODE_CRC) begin
            first_sum_in = crc_next;
         end else begin
            first_sum_in  = {8'd0, a_next};
            second_sum_in = b_next;
         end
         if (req_last_of_block) begin
            rsp_valid_in    = 1'b1;
            rsp_checksum_in = (mode_eff == sbc_pkg::MODE_CRC) ? crc_next : {b_next, a_next};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_sum_ff  <= 16'd0;
         second_sum_ff <= 8'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         first_sum_ff  <= first_sum_in;
         second_sum_ff <= second_sum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_checksum_ff <= rsp_checksum_in;
   end

endmodule

>>> hdl/sbc_checker.sv
// Port-level checker for the selectable byte checksum core.
// Watches the top level's handshakes; bound to selectable_byte_checksum_core.
// Uses no package; sees the core only through the bound ports.
module sbc_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_last_of_block,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_checksum
);

   // A stalled result beat stays.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result beat dropped");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_checksum))
      else $error("stalled checksum changed");

   // Input backpressure only while a result beat waits.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a waiting result");

   // A last byte yields a result beat next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_of_block |=> rsp_valid)
      else $error("last byte produced no checksum");

   // No result appears without a last byte or a held beat.
   assert property (@(posedge clock) disable iff (reset)
      !(req_valid && !req_stall && req_last_of_block) && !(rsp_valid && rsp_stall)
      |=> !rsp_valid)
      else $error("checksum beat without a last byte");

endmodule

bind selectable_byte_checksum_core sbc_port_checker u_sbc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_last_of_block (req_last_of_block),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_checksum      (rsp_checksum)
);

>>> test/sbc_checker.sv
// Checker for the selectable byte checksum core.
// Watches the byte, checksum and register ports, predicts each checksum and compares.
// Depends on sbc_pkg.
module sbc_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_first_of_block,
   input  logic                   req_last_of_block,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [15:0]            rsp_checksum,
   input  logic                   csr_write_enable,
   input  sbc_pkg::csr_index_type csr_index,
   input  logic [15:0]            csr_write_data,
   output int                     error_count,
   output int                     pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   sbc_pkg::mode_type mode_reg;
   sbc_pkg::crc_type  poly_reg;
   sbc_pkg::crc_type  init_reg;
   logic [15:0]       running_sum;
   logic [7:0]        running_second;
   logic [15:0]       checksum_queue[$];
   int                checksum_index;

   initial begin
      error_count = 0;
      pending_count = 0;
      checksum_index = 0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] checksum #%0d: %s", $realtime, checksum_index, what);
      error_count++;
   endtask

   // Take one byte into the running sums; returns the checksum the state now reads as.
   function automatic logic [15:0] absorb_byte(input logic [7:0] data, input logic first);
      sbc_pkg::mode_type m;
      sbc_pkg::crc_type  crc;
      int unsigned       a;
      int unsigned       b;
      int unsigned       modulus;
      m = (mode_reg > sbc_pkg::MODE_DOUBLED) ? sbc_pkg::MODE_F256 : mode_reg;
      if (m == sbc_pkg::MODE_CRC) begin
         crc = first ? init_reg : running_sum;
         crc = crc ^ {data, 8'h00};
         for (int k = 0; k < 8; k++) begin
            crc = crc[15] ? ({crc[14:0], 1'b0} ^ poly_reg) : {crc[14:0], 1'b0};
         end
         running_sum = crc;
         return crc;
      end
      a = running_sum[7:0];
      b = running_second;
      if (first) begin
         b = 0;
         if (m == sbc_pkg::MODE_ADLER) begin
            a = 1;
         end else if (m == sbc_pkg::MODE_DOUBLED) begin
            a = data;
         end else begin
            a = 0;
         end
      end
      if (m == sbc_pkg::MODE_ADLER) begin
         modulus = 251;
      end else if (m == sbc_pkg::MODE_F255) begin
         modulus = 255;
      end else begin
         modulus = 256;
      end
      a = (a + data) % modulus;
      b = (b + a) % modulus;
      running_sum = 16'(a);
      running_second = 8'(b);
      return {running_second, running_sum[7:0]};
   endfunction

   always @(posedge clock) begin
      logic [15:0] predicted;
      if (reset) begin
         mode_reg = sbc_pkg::MODE_CRC;
         poly_reg = sbc_pkg::POLY_RESET;
         init_reg = sbc_pkg::INITIAL_RESET;
         running_sum = '0;
         running_second = '0;
         checksum_queue.delete();
      end else begin
         // check the outgoing beat first: it always belongs to an earlier byte
         if (rsp_valid && !rsp_stall) begin
            if (checksum_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected beat, checksum %h", rsp_checksum));
            end else begin
               predicted = checksum_queue.pop_front();
               if (rsp_checksum !== predicted) begin
                  report_mismatch($sformatf("checksum %h, predicted %h",
                                            rsp_checksum, predicted));
               end
            end
            checksum_index++;
         end
         // a byte taken at this edge still sees the old register values
         if (req_valid && !req_stall) begin
            predicted = absorb_byte(req_data_byte, req_first_of_block);
            if (req_last_of_block) begin
               checksum_queue.push_back(predicted);
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               sbc_pkg::CSR_MODE:       mode_reg = csr_write_data[2:0];
               sbc_pkg::CSR_POLYNOMIAL: poly_reg = csr_write_data;
               sbc_pkg::CSR_INITIAL:    init_reg = csr_write_data;
               default:                 ;
            endcase
         end
      end
      pending_count <= checksum_queue.size();
   end

endmodule

>>> test/tb.sv
// Testbench top for the selectable byte checksum core.
// Drives byte blocks and register writes, stalls the checksum side; sbc_checker does the checking.
// Depends on sbc_pkg, selectable_byte_checksum_core and sbc_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam sbc_pkg::csr_index_type CSR_UNUSED = 2'd3;
   localparam int                     DIRECTED_BYTES = 24;
   localparam int                     RANDOM_BYTES = 420;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [7:0]             req_data_byte;
   logic                   req_first_of_block;
   logic                   req_last_of_block;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [15:0]            rsp_checksum;
   logic                   csr_write_enable;
   sbc_pkg::csr_index_type csr_index;
   logic [15:0]            csr_write_data;
   int                     error_count;
   int                     pending_count;
   bit                     idle_enable;
   int                     bytes_sent;

   selectable_byte_checksum_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_first_of_block (req_first_of_block),
      .req_last_of_block  (req_last_of_block),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_checksum       (rsp_checksum),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   sbc_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_first_of_block (req_first_of_block),
      .req_last_of_block  (req_last_of_block),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_checksum       (rsp_checksum),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .error_count        (error_count),
      .pending_count      (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("DONE: errors detected");
      $finish;
   end

   // random backpressure on the checksum side
   always @(negedge clock) begin
      rsp_stall <= idle_enable && ($urandom_range(99) < 9);
   end

   // Present one byte at a falling edge and hold it until the beat is taken.
   task automatic send_byte(input logic [7:0] data, input logic first, input logic last);
      @(negedge clock);
      while (idle_enable && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_first_of_block <= first;
      req_last_of_block <= last;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      bytes_sent++;
   endtask

   // Drop valid and wait until every predicted checksum has left the block.
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_count == 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_register(input sbc_pkg::csr_index_type index,
                                 input logic [15:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [15:0] pick_word();
      case ($urandom_range(5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return sbc_pkg::POLY_RESET;
         default: return 16'($urandom_range(16'hFFFF));
      endcase
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Well-formed blocks flag only their ends; broken ones get random flags.
   task automatic send_block(input int length, input bit broken);
      logic first;
      logic last;
      for (int i = 0; i < length; i++) begin
         first = broken ? 1'($urandom_range(1)) : (i == 0);
         last = broken ? 1'($urandom_range(1)) : (i == length - 1);
         send_byte(pick_byte(), first, last);
      end
   endtask

   initial begin
      sbc_pkg::mode_type mode_pick;
      int                phase;
      int                block_count;
      int                length;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_first_of_block = 1'b0;
      req_last_of_block = 1'b0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = sbc_pkg::CSR_MODE;
      csr_write_data = '0;
      idle_enable = 1'b1;
      bytes_sent = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // byte with no block started: continues from the cleared state
      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'hFF, 1'b1, 1'b0);
      send_byte(8'h80, 1'b0, 1'b0);
      send_byte(8'h01, 1'b0, 1'b1);
      drain();
      write_register(sbc_pkg::CSR_POLYNOMIAL, 16'hFFFF);
      write_register(sbc_pkg::CSR_INITIAL, 16'h0000);
      send_byte(8'hFF, 1'b1, 1'b1);
      send_byte(8'h00, 1'b1, 1'b1);
      drain();
      write_register(sbc_pkg::CSR_POLYNOMIAL, 16'h0000);
      write_register(sbc_pkg::CSR_INITIAL, 16'hFFFF);
      write_register(CSR_UNUSED, 16'hFFFF);
      send_byte(8'h5A, 1'b1, 1'b1);
      // sum modes with the top register bits set; all-ones bytes force wrap-around
      for (int m = sbc_pkg::MODE_ADLER; m <= sbc_pkg::MODE_DOUBLED; m++) begin
         drain();
         write_register(sbc_pkg::CSR_MODE, 16'hFFF8 | 16'(m));
         send_byte(8'hFF, 1'b1, 1'b0);
         send_byte(8'hFF, 1'b0, 1'b0);
         send_byte(8'h00, 1'b0, 1'b1);
      end
      // unused mode codes fall back to the modulo-256 sum
      drain();
      write_register(sbc_pkg::CSR_MODE, 16'h0005);
      send_byte(8'hFF, 1'b1, 1'b1);
      drain();
      write_register(sbc_pkg::CSR_MODE, 16'h0007);
      send_byte(8'h80, 1'b1, 1'b1);
      send_byte(8'h10, 1'b0, 1'b1);
      // switch mode in the middle of a block
      drain();
      write_register(sbc_pkg::CSR_MODE, 16'(sbc_pkg::MODE_DOUBLED));
      send_byte(8'hC3, 1'b1, 1'b0);
      drain();
      write_register(sbc_pkg::CSR_MODE, 16'(sbc_pkg::MODE_F255));
      send_byte(8'hFF, 1'b0, 1'b1);

      phase = 0;
      while (bytes_sent < DIRECTED_BYTES + RANDOM_BYTES) begin
         drain();
         idle_enable = (phase % 5 != 2);
         length = $urandom_range(9);
         mode_pick = (length < 8) ? sbc_pkg::mode_type'(length % 5)
                                  : sbc_pkg::mode_type'($urandom_range(7, 5));
         write_register(sbc_pkg::CSR_MODE, {13'($urandom_range(16'h1FFF)), mode_pick});
         write_register(sbc_pkg::CSR_POLYNOMIAL, pick_word());
         write_register(sbc_pkg::CSR_INITIAL, pick_word());
         if ($urandom_range(3) == 0) begin
            write_register(CSR_UNUSED, pick_word());
         end
         block_count = $urandom_range(10, 3);
         for (int k = 0; k < block_count; k++) begin
            length = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(6, 1);
            send_block(length, $urandom_range(9) == 0);
         end
         phase++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_count == 0);
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
